@@ sv/mcid_pkg.sv @@
// Shared types and constants for the multi-channel input debouncer.
// Holds the per-channel state layout, the response layout and the register indexes.
// No dependencies.
package mcid_pkg;

   localparam int NUM_CHANNELS   = 4;
   localparam int CH_AW          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHAN_W         = 3;
   localparam int TIME_W         = 32;
   localparam int DELAY_W        = 16;
   localparam int NUM_DELAY_REGS = 4;
   localparam int POL_W          = 4;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_CH0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_CH1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_CH2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_CH3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVELS = 3'd4;

   typedef struct packed {
      logic              prev_sample;
      logic              accepted_level;
      logic [TIME_W-1:0] change_time;
      logic              accepted_once;
      logic              active_flag;
      logic              stable_flag;
   } chan_state_type;

   localparam int STATE_W = $bits(chan_state_type);

   typedef struct packed {
      logic is_active;
      logic is_stable;
      logic bad_channel;
   } rsp_type;

   localparam int QUEUE_DEPTH = 3;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

@@ sv/multi_channel_input_debouncer.sv @@
// Top level of the multi-channel input debouncer: request capture, state update, CSRs.
// Depends on mcid_pkg, mcid_ram and mcid_rsp_queue.
//
// One request per cycle is taken while req_stall is low; each gives one response.
// A request reads its channel's state from a RAM in the cycle it is taken, the next cycle
// updates and writes it back and queues the response; back-to-back requests to the same
// channel see the just-written state through a bypass. A three-deep response queue lets
// requests keep flowing while a response waits. Channel state reads as zero after reset
// through per-channel valid bits, so no clearing pass is needed. Write the delay and
// polarity registers only while no request is in flight.
module multi_channel_input_debouncer
   import mcid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic                  req_pin_level,
   input  logic [TIME_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_active,
   output logic                  rsp_is_stable,
   output logic                  rsp_bad_channel,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [DELAY_W-1:0]      delay_ff [NUM_DELAY_REGS];
   logic [POL_W-1:0]        active_levels_ff;

   logic                    req_accept;
   logic                    s1_vld_ff;
   logic [CH_AW-1:0]        s1_addr_ff;
   logic                    s1_bad_ff;
   logic                    s1_lvl_ff;
   logic [TIME_W-1:0]       s1_now_ff;

   logic [NUM_CHANNELS-1:0] ent_vld_ff, ent_vld_in;
   logic                    byp_vld_ff;
   logic [CH_AW-1:0]        byp_addr_ff;
   chan_state_type          byp_data_ff;

   logic [STATE_W-1:0]      ram_rd_data;
   logic                    ram_wr_en;
   chan_state_type          cur_state;
   chan_state_type          new_state;
   logic [TIME_W-1:0]       elapsed;
   rsp_type                 s1_rsp;
   rsp_type                 q_head;
   logic [QCNT_W-1:0]       q_count;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DELAY_REGS; i++) begin
            delay_ff[i] <= DELAY_W'(50);
         end
         active_levels_ff <= POL_W'(3);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DELAY_CH0:     delay_ff[0] <= csr_data;
            CSR_DELAY_CH1:     delay_ff[1] <= csr_data;
            CSR_DELAY_CH2:     delay_ff[2] <= csr_data;
            CSR_DELAY_CH3:     delay_ff[3] <= csr_data;
            CSR_ACTIVE_LEVELS: active_levels_ff <= csr_data[POL_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   assign req_stall  = ({1'b0, q_count} + (QCNT_W + 1)'(s1_vld_ff)) >=
                       (QCNT_W + 1)'(QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff <= req_channel[CH_AW-1:0];
         s1_bad_ff  <= (req_channel >= CHAN_W'(NUM_CHANNELS));
         s1_lvl_ff  <= req_pin_level;
         s1_now_ff  <= req_now_ms;
      end
   end

   mcid_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_state),
      .rd_addr (req_channel[CH_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // read-modify-write of the channel state
   always_comb begin
      if (byp_vld_ff && (byp_addr_ff == s1_addr_ff)) begin
         cur_state = byp_data_ff;
      end else if (ent_vld_ff[s1_addr_ff]) begin
         cur_state = chan_state_type'(ram_rd_data);
      end else begin
         cur_state = '0;
      end
   end

   always_comb begin
      new_state = cur_state;
      if (s1_lvl_ff != cur_state.prev_sample) begin
         new_state.change_time = s1_now_ff;
         new_state.active_flag = 1'b0;
         new_state.stable_flag = 1'b0;
      end
      elapsed = s1_now_ff - new_state.change_time;
      if (elapsed > {{(TIME_W - DELAY_W){1'b0}}, delay_ff[s1_addr_ff]}) begin
         new_state.stable_flag = 1'b1;
         if ((s1_lvl_ff != cur_state.accepted_level) || !cur_state.accepted_once) begin
            new_state.accepted_level = s1_lvl_ff;
            new_state.active_flag    = (s1_lvl_ff == active_levels_ff[s1_addr_ff]);
            new_state.accepted_once  = 1'b1;
         end
      end
      new_state.prev_sample = s1_lvl_ff;
   end

   assign ram_wr_en = s1_vld_ff && !s1_bad_ff;

   always_comb begin
      ent_vld_in = ent_vld_ff;
      if (ram_wr_en) begin
         ent_vld_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
         byp_vld_ff <= 1'b0;
      end else begin
         ent_vld_ff <= ent_vld_in;
         byp_vld_ff <= ram_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         byp_addr_ff <= s1_addr_ff;
         byp_data_ff <= new_state;
      end
   end

   // response
   always_comb begin
      if (s1_bad_ff) begin
         s1_rsp = '{is_active: 1'b0, is_stable: 1'b0, bad_channel: 1'b1};
      end else begin
         s1_rsp = '{is_active: new_state.active_flag, is_stable: new_state.stable_flag,
                    bad_channel: 1'b0};
      end
   end

   mcid_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_vld_ff),
      .push_data  (s1_rsp),
      .pop        (rsp_valid && !rsp_stall),
      .head_valid (rsp_valid),
      .head_data  (q_head),
      .count      (q_count)
   );

   assign rsp_is_active   = q_head.is_active;
   assign rsp_is_stable   = q_head.is_stable;
   assign rsp_bad_channel = q_head.bad_channel;

   a_accept_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_vld_ff)
      else $error("accepted request did not reach update stage");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, q_count} + (QCNT_W + 1)'(s1_vld_ff)) <= (QCNT_W + 1)'(QUEUE_DEPTH))
      else $error("response queue could overflow");

   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_bad_ff) |-> !ram_wr_en)
      else $error("invalid channel wrote state");

   a_bad_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_channel) |-> (!rsp_is_active && !rsp_is_stable))
      else $error("invalid channel response has flags set");

endmodule

@@ sv/mcid_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Width and depth are parameters; no package dependency.
module mcid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mcid_rsp_queue.sv @@
// Small response queue that decouples the update stage from the response stall.
// Depends on mcid_pkg for the response layout and queue depth.
module mcid_rsp_queue
   import mcid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_type           push_data,
   input  logic              pop,
   output logic              head_valid,
   output rsp_type           head_data,
   output logic [QCNT_W-1:0] count
);

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[head_ff];
   assign count      = count_ff;

endmodule
